### hw/rtl/ia64_pkg.sv
// ----------------------------------------------------------------------------
// ia64_pkg: shared types and codes of the integer ALU
// Operation codes, divide-chain kinds and the records that travel between
// the front stage and the divide cells.
// ----------------------------------------------------------------------------
package ia64_pkg;

	localparam int unsigned XLEN = 64;
	localparam int unsigned HLEN = 32;

	typedef enum logic [5:0] {
		OP_ADD = 6'd0, OP_SUB = 6'd1, OP_SMUL = 6'd2, OP_UMUL = 6'd3,
		OP_SDIV = 6'd4, OP_UDIV = 6'd5, OP_SMOD = 6'd6, OP_UMOD = 6'd7,
		OP_AND = 6'd8, OP_OR = 6'd9, OP_XOR = 6'd10, OP_SHL = 6'd11,
		OP_SHR = 6'd12, OP_ASHR = 6'd13, OP_ROL = 6'd14, OP_ROR = 6'd15,
		OP_EQ = 6'd16, OP_NE = 6'd17, OP_SLT = 6'd18, OP_SLE = 6'd19,
		OP_SGT = 6'd20, OP_SGE = 6'd21, OP_ULT = 6'd22, OP_ULE = 6'd23,
		OP_UGT = 6'd24, OP_UGE = 6'd25, OP_MOV = 6'd26, OP_NEG = 6'd27,
		OP_NOT = 6'd28, OP_MKBOOL = 6'd29, OP_NOTBOOL = 6'd30, OP_ZXT = 6'd31,
		OP_SXT = 6'd32
	} op_t;

	typedef enum logic [1:0] {
		KIND_NONE = 2'd0,
		KIND_QUOT = 2'd1,
		KIND_REM  = 2'd2
	} kind_t;

	// front stage record
	typedef struct packed {
		logic              valid;
		kind_t             kind;
		logic              neg;
		logic              dz;
		logic              w32;
		logic              is_mul;
		logic [XLEN-1:0]   res;
		logic [XLEN-1:0]   ll;
		logic [HLEN-1:0]   lh;
		logic [HLEN-1:0]   hl;
		logic [XLEN-1:0]   ma;
		logic [XLEN-1:0]   mb;
	} prep_t;

	// divide cell record
	typedef struct packed {
		logic              valid;
		kind_t             kind;
		logic              neg;
		logic              dz;
		logic              w32;
		logic [XLEN-1:0]   res;
		logic [XLEN-1:0]   r;
		logic [XLEN-1:0]   n;
		logic [XLEN-1:0]   d;
	} cell_t;

endpackage

### hw/rtl/ia64_req_if.sv
// ----------------------------------------------------------------------------
// ia64_req_if: request channel of the integer ALU
// Valid/ready handshake carrying one operation and its operands.
// ----------------------------------------------------------------------------
interface ia64_req_if;
	logic        valid;
	logic        ready;
	logic [5:0]  op;
	logic        word32;
	logic [63:0] operand_a;
	logic [63:0] operand_b;
	logic [3:0]  size_bytes;

	modport source (output valid, output op, output word32, output operand_a,
		output operand_b, output size_bytes, input ready);
	modport sink (input valid, input op, input word32, input operand_a,
		input operand_b, input size_bytes, output ready);
endinterface

### hw/rtl/ia64_rsp_if.sv
// ----------------------------------------------------------------------------
// ia64_rsp_if: result channel of the integer ALU
// Valid/ready handshake carrying one 64-bit result.
// ----------------------------------------------------------------------------
interface ia64_rsp_if;
	logic        valid;
	logic        ready;
	logic [63:0] result;

	modport source (output valid, output result, input ready);
	modport sink (input valid, input result, output ready);
endinterface

### hw/rtl/ia64_prep.sv
// ----------------------------------------------------------------------------
// ia64_prep: front stage of the integer ALU
// Decode the request, evaluate all single-step operations, form the multiply
// partial products and the divide magnitudes, and register them.
// ----------------------------------------------------------------------------
module ia64_prep (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  adv,
	input  logic                  valid,
	input  logic [5:0]            op,
	input  logic                  word32,
	input  logic [63:0]           operand_a,
	input  logic [63:0]           operand_b,
	input  logic [3:0]            size_bytes,
	output ia64_pkg::prep_t       prep_s1
);

	logic [63:0] mask, ua, ub, sa, sb, res, ma, mb, extm, zx, sx;
	logic [6:0]  width, bits;
	logic [5:0]  c;
	logic        na, nb, xsgn;
	ia64_pkg::prep_t nxt;

	assign mask  = word32 ? 64'h0000_0000_FFFF_FFFF : '1;
	assign ua    = operand_a & mask;
	assign ub    = operand_b & mask;
	assign sa    = word32 ? {{32{ua[31]}}, ua[31:0]} : ua;
	assign sb    = word32 ? {{32{ub[31]}}, ub[31:0]} : ub;
	assign width = word32 ? 7'd32 : 7'd64;
	assign c     = word32 ? {1'b0, ub[4:0]} : ub[5:0];
	assign bits  = {size_bytes, 3'b000};
	assign na    = sa[63];
	assign nb    = sb[63];
	assign extm  = (64'd1 << bits[5:0]) - 64'd1;
	assign zx    = ua & extm;
	assign xsgn  = ua[bits[5:0] - 6'd1];
	assign sx    = xsgn ? (zx | ~extm) : zx;

	always_comb begin
		res = '0;
		case (ia64_pkg::op_t'(op))
			ia64_pkg::OP_ADD:     res = ua + ub;
			ia64_pkg::OP_SUB:     res = ua - ub;
			ia64_pkg::OP_AND:     res = ua & ub;
			ia64_pkg::OP_OR:      res = ua | ub;
			ia64_pkg::OP_XOR:     res = ua ^ ub;
			ia64_pkg::OP_SHL:     res = ua << c;
			ia64_pkg::OP_SHR:     res = ua >> c;
			ia64_pkg::OP_ASHR:    res = $unsigned($signed(sa) >>> c);
			ia64_pkg::OP_ROL:     res = (c == 6'd0) ? ua :
				((ua << c) | (ua >> (width - {1'b0, c})));
			ia64_pkg::OP_ROR:     res = (c == 6'd0) ? ua :
				((ua >> c) | (ua << (width - {1'b0, c})));
			ia64_pkg::OP_EQ:      res = {63'd0, ua == ub};
			ia64_pkg::OP_NE:      res = {63'd0, ua != ub};
			ia64_pkg::OP_SLT:     res = {63'd0, $signed(sa) <  $signed(sb)};
			ia64_pkg::OP_SLE:     res = {63'd0, $signed(sa) <= $signed(sb)};
			ia64_pkg::OP_SGT:     res = {63'd0, $signed(sa) >  $signed(sb)};
			ia64_pkg::OP_SGE:     res = {63'd0, $signed(sa) >= $signed(sb)};
			ia64_pkg::OP_ULT:     res = {63'd0, ua <  ub};
			ia64_pkg::OP_ULE:     res = {63'd0, ua <= ub};
			ia64_pkg::OP_UGT:     res = {63'd0, ua >  ub};
			ia64_pkg::OP_UGE:     res = {63'd0, ua >= ub};
			ia64_pkg::OP_MOV:     res = ua;
			ia64_pkg::OP_NEG:     res = 64'd0 - ua;
			ia64_pkg::OP_NOT:     res = ~ua;
			ia64_pkg::OP_MKBOOL:  res = {63'd0, ua != 64'd0};
			ia64_pkg::OP_NOTBOOL: res = {63'd0, ua == 64'd0};
			ia64_pkg::OP_ZXT:     res = (bits == 7'd0) ? 64'd0 : (bits >= width) ? ua : zx;
			ia64_pkg::OP_SXT:     res = (bits == 7'd0) ? 64'd0 : (bits >= width) ? ua : sx;
			default:              res = '0;
		endcase
	end

	always_comb begin
		nxt.valid  = valid;
		nxt.kind   = ia64_pkg::KIND_NONE;
		nxt.neg    = 1'b0;
		nxt.w32    = word32;
		nxt.is_mul = (op == ia64_pkg::OP_SMUL) || (op == ia64_pkg::OP_UMUL);
		nxt.res    = res;
		nxt.ll     = 64'(ua[31:0]) * 64'(ub[31:0]);
		nxt.lh     = 32'(ua[31:0] * ub[63:32]);
		nxt.hl     = 32'(ua[63:32] * ub[31:0]);
		ma = ua;
		mb = ub;
		case (ia64_pkg::op_t'(op))
			ia64_pkg::OP_SDIV: begin
				nxt.kind = ia64_pkg::KIND_QUOT;
				nxt.neg  = na ^ nb;
				ma = na ? 64'd0 - sa : sa;
				mb = nb ? 64'd0 - sb : sb;
			end
			ia64_pkg::OP_SMOD: begin
				nxt.kind = ia64_pkg::KIND_REM;
				nxt.neg  = na;
				ma = na ? 64'd0 - sa : sa;
				mb = nb ? 64'd0 - sb : sb;
			end
			ia64_pkg::OP_UDIV: nxt.kind = ia64_pkg::KIND_QUOT;
			ia64_pkg::OP_UMOD: nxt.kind = ia64_pkg::KIND_REM;
			default: nxt.kind = ia64_pkg::KIND_NONE;
		endcase
		nxt.ma = ma;
		nxt.mb = mb;
		nxt.dz = (mb == 64'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prep_s1 <= '0;
		end else if (adv) begin
			prep_s1 <= nxt;
		end
	end

endmodule

### hw/rtl/ia64_div_cell.sv
// ----------------------------------------------------------------------------
// ia64_div_cell: one restoring-division cell
// Shift one dividend bit into the partial remainder, subtract the divisor
// when it fits, and hand the record to the next cell.
// ----------------------------------------------------------------------------
module ia64_div_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  ia64_pkg::cell_t   prev,
	output ia64_pkg::cell_t   cur_q
);

	logic [64:0] t, diff;
	logic        ge;

	assign t    = {prev.r, prev.n[63]};
	assign diff = t - {1'b0, prev.d};
	assign ge   = (t >= {1'b0, prev.d});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= '0;
		end else if (adv) begin
			cur_q.valid <= prev.valid;
			cur_q.kind  <= prev.kind;
			cur_q.neg   <= prev.neg;
			cur_q.dz    <= prev.dz;
			cur_q.w32   <= prev.w32;
			cur_q.res   <= prev.res;
			cur_q.d     <= prev.d;
			cur_q.r     <= ge ? diff[63:0] : t[63:0];
			cur_q.n     <= {prev.n[62:0], ge};
		end
	end

endmodule

### hw/rtl/integer_alu_32_64_unit.sv
// ----------------------------------------------------------------------------
// integer_alu_32_64_unit: pipelined 64/32-bit integer ALU with divide
// Path from request acceptance to result valid: front stage, 64 divide
// cells, output register; every operation takes the same path.
// Throughput: one request per cycle while the output register is empty or
// being taken; otherwise the whole pipe stalls.
// Reset: arst_n clears the front stage and every divide cell; the result
// data register is not reset.
// ----------------------------------------------------------------------------
module integer_alu_32_64_unit (
	input  logic        clk,
	input  logic        arst_n,
	ia64_req_if.sink    req,
	ia64_rsp_if.source  rsp
);

	localparam int unsigned NCELL = ia64_pkg::XLEN;

	ia64_pkg::prep_t prep_s1;
	ia64_pkg::cell_t chain [NCELL+1];
	logic            adv;
	logic            rsp_valid_q;
	logic [63:0]     rsp_result_q;
	logic [63:0]     mag, signed_val, val;
	ia64_pkg::cell_t last;

	// advance every stage together; the output register frees a slot when
	// it is empty or its result is taken this cycle
	assign adv       = !rsp_valid_q || rsp.ready;
	assign req.ready = adv;

	ia64_prep u_prep (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.valid      (req.valid),
		.op         (req.op),
		.word32     (req.word32),
		.operand_a  (req.operand_a),
		.operand_b  (req.operand_b),
		.size_bytes (req.size_bytes),
		.prep_s1    (prep_s1)
	);

	// load the first cell: fold the multiply partials into the carried
	// result, start the remainder at zero with the dividend magnitude
	always_comb begin
		chain[0].valid = prep_s1.valid;
		chain[0].kind  = prep_s1.kind;
		chain[0].neg   = prep_s1.neg;
		chain[0].dz    = prep_s1.dz;
		chain[0].w32   = prep_s1.w32;
		chain[0].res   = prep_s1.is_mul ?
			(prep_s1.ll + {prep_s1.lh + prep_s1.hl, 32'd0}) : prep_s1.res;
		chain[0].r     = '0;
		chain[0].n     = prep_s1.ma;
		chain[0].d     = prep_s1.mb;
	end

	// one quotient bit per cell, most significant first
	for (genvar i = 0; i < NCELL; i++) begin : g_cell
		ia64_div_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.adv    (adv),
			.prev   (chain[i]),
			.cur_q  (chain[i+1])
		);
	end

	// pick quotient, remainder or the carried result, apply the sign, give
	// zero on divide by zero, then sign-extend 32-bit results
	assign last       = chain[NCELL];
	assign mag        = (last.kind == ia64_pkg::KIND_QUOT) ? last.n : last.r;
	assign signed_val = last.dz ? 64'd0 : (last.neg ? 64'd0 - mag : mag);

	always_comb begin
		case (last.kind)
			ia64_pkg::KIND_QUOT, ia64_pkg::KIND_REM: val = signed_val;
			default:                                 val = last.res;
		endcase
		if (last.w32) begin
			val = {{32{val[31]}}, val[31:0]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv) begin
			rsp_valid_q <= last.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rsp_result_q <= val;
		end
	end

	assign rsp.valid  = rsp_valid_q;
	assign rsp.result = rsp_result_q;

endmodule

### hw/rtl/ia64_checker.sv
// ----------------------------------------------------------------------------
// ia64_checker: port-level checks of the integer ALU
// Watch the handshakes on both channels and the flow control between them.
// ----------------------------------------------------------------------------
module ia64_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_ready,
	input  logic        rsp_valid,
	input  logic        rsp_ready,
	input  logic [63:0] rsp_result
);

	// hold a stalled result
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result))
		else $error("stalled result changed");

	// accept requests whenever the output register is empty
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid |-> req_ready)
		else $error("request stalled with empty output");

	// refuse requests only while the result is stalled
	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!req_ready |-> rsp_valid && !rsp_ready)
		else $error("request stalled without output backpressure");

endmodule

bind integer_alu_32_64_unit ia64_checker u_ia64_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_ready  (req.ready),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.rsp_result (rsp.result)
);

### bench/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench of the integer ALU
// Drives random and corner-case operations through the request channel,
// predicts each result in a local model and compares results in order.
// ----------------------------------------------------------------------------
module tb;

	localparam int unsigned LATENCY = 65;
	localparam int unsigned WATCHDOG_LIMIT = 20000;
	localparam int unsigned RANDOM_COUNT = 1430;
	localparam logic [63:0] MIN64 = 64'h8000_0000_0000_0000;

	// Hold expected results in request order and count mismatches.
	class result_board;
		logic [63:0] pending[$];
		int errors;

		function void note(input logic [63:0] value);
			pending.push_back(value);
		endfunction

		function void check(input logic [63:0] actual);
			logic [63:0] want;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result %h", actual);
				return;
			end
			want = pending.pop_front();
			if (want !== actual) begin
				errors++;
				if (errors <= 10)
					$display("result mismatch: expected %h actual %h", want, actual);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic idle_free = 1'b0;
	int unsigned quiet_cycles = 0;
	bit timed_out = 1'b0;
	result_board board;

	ia64_req_if req ();
	ia64_rsp_if rsp ();

	integer_alu_32_64_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp)
	);

	always #1 clk = ~clk;

	// Sign-extend the low 'bits' bits of x.
	function automatic logic [63:0] sext_bits(input logic [63:0] x, input int bits);
		logic [63:0] m;
		m = (bits >= 64) ? '1 : ((64'd1 << bits) - 64'd1);
		x = x & m;
		if (x[bits-1])
			x = x | ~m;
		return x;
	endfunction

	// Compute the ALU result of one request.
	function automatic logic [63:0] alu_result(input logic [5:0] op, input logic w32,
			input logic [63:0] a, input logic [63:0] b, input logic [3:0] size);
		int width;
		int sh;
		int bits;
		logic [63:0] mask, ua, ub, sa, sb, ma, mb, q, r;
		logic na, nb;
		width = w32 ? 32 : 64;
		mask = w32 ? 64'hFFFF_FFFF : '1;
		ua = a & mask;
		ub = b & mask;
		sa = w32 ? sext_bits(ua, 32) : ua;
		sb = w32 ? sext_bits(ub, 32) : ub;
		sh = int'(ub & 64'(width - 1));
		bits = int'(size) * 8;
		na = sa[63];
		nb = sb[63];
		ma = na ? -sa : sa;
		mb = nb ? -sb : sb;
		case (op)
			ia64_pkg::OP_ADD: r = ua + ub;
			ia64_pkg::OP_SUB: r = ua - ub;
			ia64_pkg::OP_SMUL, ia64_pkg::OP_UMUL: r = ua * ub;
			ia64_pkg::OP_SDIV: begin
				q = (mb == 0) ? 64'd0 : ma / mb;
				r = (mb == 0) ? 64'd0 : ((na != nb) ? -q : q);
			end
			ia64_pkg::OP_UDIV: r = (ub == 0) ? 64'd0 : ua / ub;
			ia64_pkg::OP_SMOD: begin
				q = (mb == 0) ? 64'd0 : ma % mb;
				r = na ? -q : q;
			end
			ia64_pkg::OP_UMOD: r = (ub == 0) ? 64'd0 : ua % ub;
			ia64_pkg::OP_AND: r = ua & ub;
			ia64_pkg::OP_OR: r = ua | ub;
			ia64_pkg::OP_XOR: r = ua ^ ub;
			ia64_pkg::OP_SHL: r = ua << sh;
			ia64_pkg::OP_SHR: r = ua >> sh;
			ia64_pkg::OP_ASHR: r = na ? ~((~sa) >> sh) : (sa >> sh);
			ia64_pkg::OP_ROL: r = (sh == 0) ? ua : ((ua << sh) | (ua >> (width - sh)));
			ia64_pkg::OP_ROR: r = (sh == 0) ? ua : ((ua >> sh) | (ua << (width - sh)));
			ia64_pkg::OP_EQ: r = 64'(ua == ub);
			ia64_pkg::OP_NE: r = 64'(ua != ub);
			ia64_pkg::OP_SLT: r = 64'($signed(sa) < $signed(sb));
			ia64_pkg::OP_SLE: r = 64'($signed(sa) <= $signed(sb));
			ia64_pkg::OP_SGT: r = 64'($signed(sa) > $signed(sb));
			ia64_pkg::OP_SGE: r = 64'($signed(sa) >= $signed(sb));
			ia64_pkg::OP_ULT: r = 64'(ua < ub);
			ia64_pkg::OP_ULE: r = 64'(ua <= ub);
			ia64_pkg::OP_UGT: r = 64'(ua > ub);
			ia64_pkg::OP_UGE: r = 64'(ua >= ub);
			ia64_pkg::OP_MOV: r = ua;
			ia64_pkg::OP_NEG: r = -ua;
			ia64_pkg::OP_NOT: r = ~ua;
			ia64_pkg::OP_MKBOOL: r = 64'(ua != 0);
			ia64_pkg::OP_NOTBOOL: r = 64'(ua == 0);
			ia64_pkg::OP_ZXT: r = (bits == 0) ? 64'd0 :
				(bits >= width) ? ua : (ua & ((64'd1 << bits) - 64'd1));
			ia64_pkg::OP_SXT: r = (bits == 0) ? 64'd0 :
				(bits >= width) ? ua : sext_bits(ua, bits);
			default: r = 64'd0;
		endcase
		if (w32)
			r = sext_bits(r, 32);
		return r;
	endfunction

	// Pick an operand biased toward edge values.
	function automatic logic [63:0] pick_operand();
		case ($urandom_range(0, 9))
			0: return 64'd0;
			1: return '1;
			2: return MIN64;
			3: return 64'h0000_0000_8000_0000;
			4: return 64'(int'($urandom_range(0, 70)));
			5: return {32'(int'($urandom)), 32'hFFFF_FFFF};
			default: return {32'($urandom), 32'($urandom)};
		endcase
	endfunction

	// Send one request: drive it, hold until accepted, then maybe idle.
	task automatic send_request(input logic [5:0] op, input logic w32,
			input logic [63:0] a, input logic [63:0] b, input logic [3:0] size);
		req.valid <= 1'b1;
		req.op <= op;
		req.word32 <= w32;
		req.operand_a <= a;
		req.operand_b <= b;
		req.size_bytes <= size;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		board.note(alu_result(op, w32, a, b, size));
		// Insert idle cycles about 17 percent of the time outside the quiet stretch.
		if (!idle_free && $urandom_range(0, 99) < 17) begin
			req.valid <= 1'b0;
			req.op <= 6'($urandom);
			req.operand_a <= {32'($urandom), 32'($urandom)};
			@(posedge clk);
			while (!idle_free && $urandom_range(0, 99) < 17)
				@(posedge clk);
		end
	endtask

	// Drive the result-side ready and check accepted results.
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else begin
			if (rsp.valid && rsp.ready)
				board.check(rsp.result);
			rsp.ready <= idle_free || ($urandom_range(0, 99) >= 17);
		end
	end

	// Count cycles with no handshake on either channel.
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT && !timed_out) begin
			timed_out = 1'b1;
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		logic [63:0] a;
		logic [63:0] b;
		board = new();
		req.valid = 1'b0;
		req.op = ia64_pkg::OP_ADD;
		req.word32 = 1'b0;
		req.operand_a = '0;
		req.operand_b = '0;
		req.size_bytes = 4'd0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed corners: division edges, rotate by zero, shifts, extends, add and compare edges, unknown opcodes.
		send_request(ia64_pkg::OP_SDIV, 1'b0, MIN64, '1, 4'd0);
		send_request(ia64_pkg::OP_SMOD, 1'b0, MIN64, '1, 4'd0);
		send_request(ia64_pkg::OP_SDIV, 1'b1, 64'h8000_0000, 64'hFFFF_FFFF, 4'd0);
		send_request(ia64_pkg::OP_UDIV, 1'b0, '1, 64'd0, 4'd0);
		send_request(ia64_pkg::OP_SMOD, 1'b1, 64'd7, 64'd0, 4'd0);
		send_request(ia64_pkg::OP_SDIV, 1'b0, -64'd7, 64'd2, 4'd0);
		send_request(ia64_pkg::OP_SMOD, 1'b0, -64'd7, 64'd2, 4'd0);
		send_request(ia64_pkg::OP_ROL, 1'b0, 64'h1234, 64'd64, 4'd0);
		send_request(ia64_pkg::OP_ROR, 1'b1, 64'h1234, 64'd32, 4'd0);
		send_request(ia64_pkg::OP_SHL, 1'b0, '1, 64'd63, 4'd0);
		send_request(ia64_pkg::OP_ASHR, 1'b1, 64'h8000_0000, 64'd31, 4'd0);
		send_request(ia64_pkg::OP_ZXT, 1'b0, '1, '0, 4'd8);
		send_request(ia64_pkg::OP_SXT, 1'b1, 64'h80, '0, 4'd4);
		send_request(ia64_pkg::OP_SXT, 1'b0, 64'h80, '0, 4'd1);
		send_request(ia64_pkg::OP_SXT, 1'b0, '1, '0, 4'd15);
		send_request(ia64_pkg::OP_ZXT, 1'b0, '1, '0, 4'd0);
		send_request(ia64_pkg::OP_ADD, 1'b1, 64'h7FFF_FFFF, 64'd1, 4'd0);
		send_request(ia64_pkg::OP_SLT, 1'b0, MIN64, 64'd0, 4'd0);
		send_request(6'd63, 1'b0, '1, '1, 4'd0);
		send_request(6'd33, 1'b1, '1, '1, 4'd0);

		// Pause until the pipe drains completely.
		req.valid <= 1'b0;
		@(posedge clk);
		while (board.pending.size() != 0)
			@(posedge clk);

		for (int i = 0; i < RANDOM_COUNT; i++) begin
			idle_free <= (i >= 500 && i < 700);
			a = pick_operand();
			b = pick_operand();
			send_request(($urandom_range(0, 19) == 0) ? 6'($urandom) :
				6'($urandom_range(0, 32)), 1'($urandom), a, b,
				4'($urandom));
		end
		req.valid <= 1'b0;
		idle_free <= 1'b0;

		// Drain outstanding results, then give any stray result time to appear.
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule

### integer_alu_32_64_unit.f
hw/rtl/ia64_pkg.sv
hw/rtl/ia64_req_if.sv
hw/rtl/ia64_rsp_if.sv
hw/rtl/ia64_prep.sv
hw/rtl/ia64_div_cell.sv
hw/rtl/integer_alu_32_64_unit.sv
hw/rtl/ia64_checker.sv
bench/tb.sv
